// ===== design/ptts_pkg.sv =====
package ptts_pkg;

  // Table and result sizes.
  localparam int unsigned SLOTS       = 8;
  localparam int unsigned MAX_RESULTS = 8;

  // Index and count widths derived from the sizes above.
  localparam int unsigned SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_CW = $clog2(SLOTS + 1);
  localparam int unsigned RES_IW  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int unsigned RES_CW  = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned RUNS_W  = 8;
  localparam int unsigned REMC_W  = 4;
  localparam int unsigned IN_DW   = 56;
  localparam int unsigned OUT_DW  = 32;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_ELAPSE     = 2'd2,
    OP_NONE       = 2'd3
  } opcode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_FIRED   = 2'd1,
    KIND_NOT_DUE = 2'd2
  } kind_e;

  // Payload of one table entry.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] remaining;
    logic [RUNS_W-1:0] runs_left;
    logic              endless;
  } slot_t;

  // Status of one entry update.
  typedef struct packed {
    logic valid_next;
    logic fire;
    logic retired;
    logic match;
    logic free;
  } slot_ev_t;

endpackage

// ===== design/ptts_slot_unit.sv =====
module ptts_slot_unit import ptts_pkg::*; (
  input  opcode_e           op_i,
  input  logic [ID_W-1:0]   id_i,
  input  logic [TICK_W-1:0] elapsed_i,
  input  logic              valid_i,
  input  slot_t             slot_i,
  output slot_t             slot_o,
  output slot_ev_t          ev_o
);

  logic              due;
  logic [TICK_W-1:0] rem_sub;

  // The shared subtract and compare against the elapsed ticks.
  assign due     = (slot_i.remaining <= elapsed_i);
  assign rem_sub = due ? '0 : (slot_i.remaining - elapsed_i);

  // Update of the entry under the sweep pointer.
  always_comb begin
    slot_o = slot_i;
    ev_o   = '0;
    ev_o.valid_next = valid_i;
    case (op_i)
      OP_REGISTER: begin
        if (valid_i) begin
          slot_o.remaining = rem_sub;
        end else begin
          ev_o.free = 1'b1;
        end
      end
      OP_UNREGISTER: begin
        if (valid_i && (slot_i.id == id_i)) begin
          ev_o.match      = 1'b1;
          ev_o.valid_next = 1'b0;
        end
      end
      OP_ELAPSE: begin
        if (valid_i) begin
          if (due) begin
            ev_o.fire = 1'b1;
            if (!slot_i.endless && (slot_i.runs_left <= RUNS_W'(1))) begin
              ev_o.retired    = 1'b1;
              ev_o.valid_next = 1'b0;
            end else begin
              if (!slot_i.endless) begin
                slot_o.runs_left = slot_i.runs_left - RUNS_W'(1);
              end
              slot_o.remaining = slot_i.period;
            end
          end else begin
            slot_o.remaining = rem_sub;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/periodic_task_timer_scheduler.sv =====
// Periodic task timer scheduler.
// Input channel (s_axis): one transfer carries a command; tuser holds the
// opcode (register, unregister, elapse) and tdata the task fields.
// Output channel (m_axis): each command yields one or more result transfers;
// tuser holds the result kind and tlast marks the final result of a command.
// An elapse gives one result per fired task in slot order, or one "not due"
// result; register and unregister give a single acknowledge.
// Sequence: after acceptance the sweep visits each table slot (SLOTS) in turn
// through the shared update unit, then a load state writes a new entry;
// the results then enter the output register one per cycle while the
// receiver does not stall. The next command is taken once the last
// result sits in the output register.
// Every result carries the smallest remaining count after the command and
// whether any task is active, so results start only after the full sweep.
// Reset empties the table and the output register. When the receiver
// stalls, the output register holds its transfer and the sequencer waits.
module periodic_task_timer_scheduler import ptts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // tdata: task_id[7:0], period[23:8], repeat_count[31:24], forever_req[32],
  // elapsed[48:33], zero fill above
  input  logic [IN_DW-1:0]  s_axis_tdata_i,
  // tuser: opcode[1:0]
  input  logic [1:0]        s_axis_tuser_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: error_full[0], fired_id[8:1], retired[9], removed_count[13:10],
  // next_due[29:14], timer_active[30], zero fill above
  output logic [OUT_DW-1:0] m_axis_tdata_o,
  // tuser: kind[1:0]
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_LOAD  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Captured command.
  opcode_e           op_q;
  logic [ID_W-1:0]   id_q;
  logic [TICK_W-1:0] period_q;
  logic [RUNS_W-1:0] repeat_q;
  logic              forever_q;
  logic [TICK_W-1:0] elapsed_q;

  // Table.
  logic [SLOTS-1:0]  valid_q;
  slot_t             slot_q [SLOTS];

  // Sweep bookkeeping.
  logic [SLOT_IW-1:0] idx_q, idx_d;
  logic               free_found_q, free_found_d;
  logic [SLOT_IW-1:0] free_idx_q, free_idx_d;
  logic [SLOT_CW-1:0] rm_cnt_q, rm_cnt_d;
  logic [TICK_W-1:0]  min_q, min_d;
  logic               any_q, any_d;

  // Fire records.
  logic [ID_W-1:0]    fire_id_q  [MAX_RESULTS];
  logic               fire_ret_q [MAX_RESULTS];
  logic [RES_CW-1:0]  nfire_q, nfire_d;
  logic [RES_CW-1:0]  rd_q, rd_d;

  // Output register.
  logic               m_valid_q, m_valid_d;
  logic [OUT_DW-1:0]  m_data_q;
  logic [1:0]         m_user_q;
  logic               m_last_q;

  logic      in_xfer;
  logic      sweep_end;
  slot_t     upd_slot;
  slot_ev_t  upd_ev;
  logic      fire_store;
  logic      can_load;

  logic [RES_CW-1:0] n_res;
  kind_e             res_kind;
  logic              res_err;
  logic [ID_W-1:0]   res_id;
  logic              res_ret;
  logic [REMC_W-1:0] res_rem;
  logic              res_last;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign sweep_end       = (idx_q == SLOT_IW'(SLOTS - 1));

  ptts_slot_unit u_slot_unit (
    .op_i      (op_q),
    .id_i      (id_q),
    .elapsed_i (elapsed_q),
    .valid_i   (valid_q[idx_q]),
    .slot_i    (slot_q[idx_q]),
    .slot_o    (upd_slot),
    .ev_o      (upd_ev)
  );

  assign fire_store = (state_q == ST_SWEEP) && upd_ev.fire &&
                      (nfire_q < RES_CW'(MAX_RESULTS));
  assign can_load   = !m_valid_q || m_axis_tready_i;

  // Result fields for the record under the read pointer.
  always_comb begin
    if ((op_q == OP_ELAPSE) && (nfire_q != '0)) begin
      n_res = nfire_q;
    end else begin
      n_res = RES_CW'(1);
    end
    res_kind = KIND_ACK;
    res_err  = 1'b0;
    res_id   = '0;
    res_ret  = 1'b0;
    res_rem  = '0;
    case (op_q)
      OP_REGISTER: begin
        res_err = !free_found_q;
      end
      OP_UNREGISTER: begin
        if (rm_cnt_q > SLOT_CW'((1 << REMC_W) - 1)) begin
          res_rem = '1;
        end else begin
          res_rem = REMC_W'(rm_cnt_q);
        end
      end
      OP_ELAPSE: begin
        if (nfire_q != '0) begin
          res_kind = KIND_FIRED;
          res_id   = fire_id_q[rd_q[RES_IW-1:0]];
          res_ret  = fire_ret_q[rd_q[RES_IW-1:0]];
        end else begin
          res_kind = KIND_NOT_DUE;
        end
      end
      default: begin
      end
    endcase
    res_last = (RES_CW'(rd_q + 1'b1) == n_res);
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    rm_cnt_d     = rm_cnt_q;
    min_d        = min_q;
    any_d        = any_q;
    nfire_d      = nfire_q;
    rd_d         = rd_q;
    m_valid_d    = m_valid_q;
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d      = ST_SWEEP;
          idx_d        = '0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          rm_cnt_d     = '0;
          min_d        = '0;
          any_d        = 1'b0;
          nfire_d      = '0;
          rd_d         = '0;
        end
      end
      ST_SWEEP: begin
        if (upd_ev.free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (upd_ev.match) begin
          rm_cnt_d = rm_cnt_q + 1'b1;
        end
        if (fire_store) begin
          nfire_d = nfire_q + 1'b1;
        end
        if (upd_ev.valid_next && (!any_q || (upd_slot.remaining < min_q))) begin
          min_d = upd_slot.remaining;
          any_d = 1'b1;
        end
        if (sweep_end) begin
          state_d = ST_LOAD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_LOAD: begin
        if ((op_q == OP_REGISTER) && free_found_q) begin
          any_d = 1'b1;
          if (!any_q || (period_q < min_q)) begin
            min_d = period_q;
          end
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (can_load) begin
          m_valid_d = 1'b1;
          rd_d      = rd_q + 1'b1;
          if (res_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      rm_cnt_q     <= '0;
      min_q        <= '0;
      any_q        <= 1'b0;
      nfire_q      <= '0;
      rd_q         <= '0;
      m_valid_q    <= 1'b0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      rm_cnt_q     <= rm_cnt_d;
      min_q        <= min_d;
      any_q        <= any_d;
      nfire_q      <= nfire_d;
      rd_q         <= rd_d;
      m_valid_q    <= m_valid_d;
      if (state_q == ST_SWEEP) begin
        valid_q[idx_q] <= upd_ev.valid_next;
      end else if ((state_q == ST_LOAD) && (op_q == OP_REGISTER) && free_found_q) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= opcode_e'(s_axis_tuser_i);
      id_q      <= s_axis_tdata_i[7:0];
      period_q  <= s_axis_tdata_i[23:8];
      repeat_q  <= s_axis_tdata_i[31:24];
      forever_q <= s_axis_tdata_i[32];
      elapsed_q <= s_axis_tdata_i[48:33];
    end
  end

  // Table payload: written back during the sweep, loaded after it.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SWEEP) begin
      slot_q[idx_q] <= upd_slot;
    end else if ((state_q == ST_LOAD) && (op_q == OP_REGISTER) && free_found_q) begin
      slot_q[free_idx_q] <= '{id:        id_q,
                              period:    period_q,
                              remaining: period_q,
                              runs_left: repeat_q,
                              endless:   forever_q};
    end
  end

  // Fire records in slot order.
  always_ff @(posedge clk_i) begin
    if (fire_store) begin
      fire_id_q[nfire_q[RES_IW-1:0]]  <= slot_q[idx_q].id;
      fire_ret_q[nfire_q[RES_IW-1:0]] <= upd_ev.retired;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && can_load) begin
      m_data_q <= {1'b0, any_q, min_q, res_rem, res_ret, res_id, res_err};
      m_user_q <= res_kind;
      m_last_q <= res_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== tb/sv/ptts_checker.sv =====
`timescale 1ns / 100ps

// Watches both stream channels of the timer scheduler. It keeps its own copy
// of the timer table, works out the results of each accepted command and
// compares every accepted result with the oldest one still due.
module ptts_checker import ptts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IN_DW-1:0]  s_axis_tdata_i,
  input  logic [1:0]        s_axis_tuser_i,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [OUT_DW-1:0] m_axis_tdata_i,
  input  logic [1:0]        m_axis_tuser_i,
  input  logic              m_axis_tlast_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  output int                mismatches_o,
  output int                outstanding_o,
  output int                results_o,
  output int                fires_o,
  output int                full_rejects_o
);

  // One timer of the shadow table.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] remaining;
    logic [RUNS_W-1:0] runs_left;
    logic              endless;
  } timer_entry_t;

  // One result as it travels on the output channel.
  typedef struct packed {
    logic [1:0]        kind;
    logic              error_full;
    logic [ID_W-1:0]   fired_id;
    logic              retired;
    logic [REMC_W-1:0] removed_count;
    logic [TICK_W-1:0] next_due;
    logic              timer_active;
    logic              last;
  } report_t;

  logic         live [SLOTS];
  timer_entry_t timers [SLOTS];
  report_t      due_reports [$];

  // Applies one command to the shadow table and queues the results it causes.
  function automatic void advance_schedule(input logic [1:0] op,
      input logic [ID_W-1:0] id, input logic [TICK_W-1:0] per,
      input logic [RUNS_W-1:0] runs, input logic endless,
      input logic [TICK_W-1:0] el);
    report_t           batch [$];
    report_t           rr;
    int                free_idx;
    int unsigned       hits;
    logic [TICK_W-1:0] low;
    logic              any_live;
    logic              gone;
    int                i;
    int                k;

    free_idx = -1;
    hits     = 0;
    rr       = '0;
    case (op)
      OP_REGISTER: begin
        // Count every live timer down first, then take the lowest free slot.
        for (i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            timers[i].remaining = (timers[i].remaining > el) ?
                                  timers[i].remaining - el : '0;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (free_idx >= 0) begin
          live[free_idx]             = 1'b1;
          timers[free_idx].id        = id;
          timers[free_idx].period    = per;
          timers[free_idx].remaining = per;
          timers[free_idx].runs_left = runs;
          timers[free_idx].endless   = endless;
        end
        rr.kind       = KIND_ACK;
        rr.error_full = (free_idx < 0);
        batch.push_back(rr);
      end
      OP_UNREGISTER: begin
        for (i = 0; i < SLOTS; i++) begin
          if (live[i] && timers[i].id == id) begin
            live[i] = 1'b0;
            hits++;
          end
        end
        rr.kind          = KIND_ACK;
        rr.removed_count = (hits > 15) ? 4'd15 : hits[REMC_W-1:0];
        batch.push_back(rr);
      end
      OP_ELAPSE: begin
        // Due timers fire in slot order; the others count down.
        for (i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            if (timers[i].remaining <= el) begin
              gone = !timers[i].endless && timers[i].runs_left <= 1;
              if (gone) begin
                live[i] = 1'b0;
              end else begin
                if (!timers[i].endless) begin
                  timers[i].runs_left = timers[i].runs_left - 1'b1;
                end
                timers[i].remaining = timers[i].period;
              end
              if (batch.size() < MAX_RESULTS) begin
                rr          = '0;
                rr.kind     = KIND_FIRED;
                rr.fired_id = timers[i].id;
                rr.retired  = gone;
                batch.push_back(rr);
              end
            end else begin
              timers[i].remaining = timers[i].remaining - el;
            end
          end
        end
        if (batch.size() == 0) begin
          rr      = '0;
          rr.kind = KIND_NOT_DUE;
          batch.push_back(rr);
        end
      end
      default: begin
        rr.kind = KIND_ACK;
        batch.push_back(rr);
      end
    endcase

    // Every result of the command carries the state after the whole command.
    low      = '0;
    any_live = 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      if (live[i] && (!any_live || timers[i].remaining < low)) begin
        low      = timers[i].remaining;
        any_live = 1'b1;
      end
    end
    for (k = 0; k < batch.size(); k++) begin
      rr              = batch[k];
      rr.next_due     = low;
      rr.timer_active = any_live;
      rr.last         = (k == batch.size() - 1);
      due_reports.push_back(rr);
    end
  endfunction

  function automatic void note_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Compares one observed result with the oldest result still due.
  function automatic void check_report(input report_t got);
    report_t want;

    results_o++;
    if (got.kind == KIND_FIRED) begin
      fires_o++;
    end
    if (got.error_full === 1'b1) begin
      full_rejects_o++;
    end
    if (due_reports.size() == 0) begin
      mismatches_o++;
      $display("%0t: result with nothing due, expected none, got %h", $time, got);
      return;
    end
    want = due_reports.pop_front();
    note_field("kind", 32'(want.kind), 32'(got.kind));
    note_field("error_full", 32'(want.error_full), 32'(got.error_full));
    note_field("fired_id", 32'(want.fired_id), 32'(got.fired_id));
    note_field("retired", 32'(want.retired), 32'(got.retired));
    note_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
    note_field("next_due", 32'(want.next_due), 32'(got.next_due));
    note_field("timer_active", 32'(want.timer_active), 32'(got.timer_active));
    note_field("last", 32'(want.last), 32'(got.last));
  endfunction

  // Results are compared before the command of the same edge is predicted,
  // since a command never yields a result at its own acceptance edge.
  always @(posedge clk_i or negedge rst_ni) begin
    report_t got;

    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        live[i]   = 1'b0;
        timers[i] = '0;
      end
      due_reports.delete();
      mismatches_o   = 0;
      outstanding_o  = 0;
      results_o      = 0;
      fires_o        = 0;
      full_rejects_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.kind          = m_axis_tuser_i;
        got.error_full    = m_axis_tdata_i[0];
        got.fired_id      = m_axis_tdata_i[8:1];
        got.retired       = m_axis_tdata_i[9];
        got.removed_count = m_axis_tdata_i[13:10];
        got.next_due      = m_axis_tdata_i[29:14];
        got.timer_active  = m_axis_tdata_i[30];
        got.last          = m_axis_tlast_i;
        check_report(got);
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        advance_schedule(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[23:8],
                         s_axis_tdata_i[31:24], s_axis_tdata_i[32],
                         s_axis_tdata_i[48:33]);
      end
      outstanding_o = due_reports.size();
    end
  end

endmodule

// ===== tb/sv/periodic_task_timer_scheduler_tb.sv =====
`timescale 1ns / 100ps

module periodic_task_timer_scheduler_tb;
  import ptts_pkg::*;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic [IN_DW-1:0]  s_tdata  = '0;
  logic [1:0]        s_tuser  = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [OUT_DW-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;
  logic              m_tvalid;
  logic              m_tready = 1'b0;

  int                mismatches;
  int                outstanding;
  int                results;
  int                fires;
  int                full_rejects;
  int                sent_by_op [4];
  int                rx_hold = 0;
  int                item;
  int                guard;
  logic              no_idle = 1'b0;
  logic [TICK_W-1:0] seen_next_due = '0;

  always #6 clk = ~clk;

  periodic_task_timer_scheduler dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  ptts_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding),
    .results_o       (results),
    .fires_o         (fires),
    .full_rejects_o  (full_rejects)
  );

  // The last compare value seen steers the elapsed ticks of later commands.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      seen_next_due <= m_tdata[29:14];
    end
  end

  // Receiver: after each transfer it may hold tready low for a while.
  initial begin
    wait (rst_n === 1'b1);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        if (rx_hold == 0) begin
          m_tready <= 1'b1;
        end
      end else if (m_tvalid && m_tready) begin
        rx_hold = no_idle ? 0 : $urandom_range(0, 16);
        if (rx_hold > 0) begin
          m_tready <= 1'b0;
        end
      end
    end
  end

  // Sends one command after a random gap and returns at its transfer edge.
  task automatic send_cmd(input opcode_e op, input logic [ID_W-1:0] id,
      input logic [TICK_W-1:0] per, input logic [RUNS_W-1:0] runs,
      input logic endless, input logic [TICK_W-1:0] el);
    int gap;

    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {{(IN_DW - 49){1'b0}}, el, endless, runs, per, id};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent_by_op[op]++;
  endtask

  // Holds off new commands until every result due so far has come.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Mostly small periods, ids from a small pool and elapsed ticks aimed at
  // the current compare value, so that timers fire, reload and retire often.
  task automatic issue_random_cmd();
    int                sel;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] per;
    logic [RUNS_W-1:0] runs;
    logic              endless;
    logic [TICK_W-1:0] el;

    sel = $urandom_range(0, 99);
    id  = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 255)) :
                                        ID_W'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       per = TICK_W'($urandom);
      1:       per = '0;
      default: per = TICK_W'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 9))
      0:       runs = RUNS_W'($urandom);
      1:       runs = '0;
      default: runs = RUNS_W'($urandom_range(1, 4));
    endcase
    endless = ($urandom_range(0, 3) == 0);
    if (sel < 38) begin
      case ($urandom_range(0, 9))
        6, 7:    el = seen_next_due;
        8:       el = TICK_W'($urandom);
        9:       el = '0;
        default: el = TICK_W'($urandom_range(0, 20));
      endcase
      send_cmd(OP_REGISTER, id, per, runs, endless, el);
    end else if (sel < 58) begin
      send_cmd(OP_UNREGISTER, id, TICK_W'($urandom), RUNS_W'($urandom), 1'($urandom),
               TICK_W'($urandom));
    end else if (sel < 96) begin
      case ($urandom_range(0, 9))
        4, 5:    el = seen_next_due - 1'b1;
        6, 7:    el = TICK_W'($urandom_range(0, 50));
        8:       el = TICK_W'($urandom);
        9:       el = '1;
        default: el = seen_next_due;
      endcase
      send_cmd(OP_ELAPSE, ID_W'($urandom), TICK_W'($urandom), RUNS_W'($urandom),
               1'($urandom), el);
    end else begin
      send_cmd(OP_NONE, ID_W'($urandom), TICK_W'($urandom), RUNS_W'($urandom),
               1'($urandom), TICK_W'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: elapse with nothing due, unregister of nothing, unused code.
    send_cmd(OP_ELAPSE, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0000);
    send_cmd(OP_UNREGISTER, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0000);
    send_cmd(OP_NONE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF);

    // Fill all eight slots: zero period, largest fields, zero repeat count,
    // a repeated id, and countdowns that saturate at zero.
    send_cmd(OP_REGISTER, 8'h00, 16'h0000, 8'h01, 1'b0, 16'h0000);
    send_cmd(OP_REGISTER, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF);
    send_cmd(OP_REGISTER, 8'h5A, 16'h0005, 8'h00, 1'b0, 16'h0000);
    send_cmd(OP_REGISTER, 8'hA5, 16'h0003, 8'h02, 1'b0, 16'h0001);
    send_cmd(OP_REGISTER, 8'h5A, 16'h0007, 8'h80, 1'b1, 16'h0002);
    send_cmd(OP_REGISTER, 8'h5A, 16'h0002, 8'h03, 1'b0, 16'h0000);
    send_cmd(OP_REGISTER, 8'h33, 16'h0001, 8'h01, 1'b1, 16'h0000);
    send_cmd(OP_REGISTER, 8'hCC, 16'h8000, 8'h7F, 1'b0, 16'h0000);

    // Table full: the register is rejected but the countdown still happens.
    send_cmd(OP_REGISTER, 8'h11, 16'h0009, 8'h01, 1'b0, 16'h0003);

    // Fires: only zero-count timers, then everything, then a single tick.
    send_cmd(OP_ELAPSE, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0000);
    send_cmd(OP_ELAPSE, 8'h00, 16'h0000, 8'h00, 1'b0, 16'hFFFF);
    send_cmd(OP_ELAPSE, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0001);

    // Unregister of an id held by several slots, then of the largest id.
    send_cmd(OP_UNREGISTER, 8'h5A, 16'h0000, 8'h00, 1'b0, 16'h0000);
    send_cmd(OP_UNREGISTER, 8'hFF, 16'h0000, 8'h00, 1'b0, 16'h0000);
    send_cmd(OP_ELAPSE, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h7FFF);
    send_cmd(OP_REGISTER, 8'hAA, 16'h5555, 8'h55, 1'b0, 16'hAAAA);

    // Let every result arrive, then elapse exactly to the compare value.
    drain_results();
    send_cmd(OP_ELAPSE, 8'h00, 16'h0000, 8'h00, 1'b0, seen_next_due);
    send_cmd(OP_UNREGISTER, 8'h33, 16'h0000, 8'h00, 1'b0, 16'h0000);

    // Random traffic, with stretches where neither side idles.
    for (item = 0; item < 500; item++) begin
      if (item % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 59) == 0) begin
        drain_results();
      end
      issue_random_cmd();
    end
    s_tvalid <= 1'b0;

    // Wait for the remaining results, then a little longer for strays.
    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    $display("Commands sent: %0d register, %0d unregister, %0d elapse, %0d unused opcode.",
             sent_by_op[OP_REGISTER], sent_by_op[OP_UNREGISTER], sent_by_op[OP_ELAPSE],
             sent_by_op[OP_NONE]);
    $display("Results checked: %0d, with %0d fires, %0d full-table rejects, %0d missing.",
             results, fires, full_rejects, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Timeout with %0d results still due.", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ptts_pkg.sv
design/ptts_slot_unit.sv
design/periodic_task_timer_scheduler.sv
tb/sv/ptts_checker.sv
tb/sv/periodic_task_timer_scheduler_tb.sv
